// ===== rtl/bfs_pkg.sv =====
// Shared types and constants for the bounded FIFO with statistics.
`default_nettype none

package bfs_pkg;

  // Fixed widths of the stream fields.
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 5;
  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 112;

  // Defaults for the top-level parameters.
  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned DATA_W_DEFAULT = 32;

  // Request kinds carried in s_tuser.
  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } bfs_req_t;

  // Result status carried in m_tuser.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NULL  = 2'd3
  } bfs_status_t;

  // Per-cell control from the queue controller.
  typedef struct packed {
    logic shift;
    logic load;
  } bfs_cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/bfs_cell.sv =====
// One storage cell of the shifting queue.
`default_nettype none

module bfs_cell
  import bfs_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  wire logic          clk,
  input  wire bfs_cell_ctl_t ctl,
  input  wire logic [W-1:0]  load_data,
  input  wire logic [W-1:0]  nbr_data,
  output logic      [W-1:0]  data
);

  logic [W-1:0] data_next;

  // A load takes the pushed value; a shift takes the neighbour's entry.
  always_comb begin
    priority if (ctl.load) begin
      data_next = load_data;
    end else if (ctl.shift) begin
      data_next = nbr_data;
    end else begin
      data_next = data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

// ===== rtl/bounded_fifo_with_stats.sv =====
// Top level of the bounded FIFO with occupancy and traffic statistics.
//
// Usage: each transaction on the slave stream is one request. s_tuser selects
// the kind (0 push, 1 pop) and s_tdata carries the value to push. Every request
// produces exactly one transaction on the master stream: m_tuser gives the
// status (success, full, empty or null push) and m_tdata the popped value, the
// occupancy after the request, the push and pop totals and the peak occupancy.
// The queue is a row of cells; the oldest entry always sits in the first cell,
// a pop shifts every cell one place towards the head and a push loads the cell
// just behind the youngest entry. Each result is registered and is shown in
// the cycle after the request that produced it, and one request is taken
// every cycle while the receiver keeps m_tready high. The result register is
// the only buffer: when the receiver stalls, s_tready drops until the held
// result has been taken, so nothing is lost.
// The configuration channel writes the usable capacity (0 reads as 1, values
// above the built depth read as the depth). Such a write empties the queue and
// clears the totals and the peak; it is meant for an idle block. Reset does the
// same and sets the capacity to 16, or to the depth where that is smaller.
`default_nettype none

module bounded_fifo_with_stats
  import bfs_pkg::*;
#(
  parameter int unsigned DEPTH  = DEPTH_DEFAULT,
  parameter int unsigned DATA_W = DATA_W_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Request stream.
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // [31:0] push_value
  input  wire logic                 s_tuser,   // [0] req_type
  // Result stream.
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // [31:0] pop_value, [36:32] occupancy, [68:37] total_pushed,
  // [100:69] total_popped, [105:101] peak_occupancy, [111:106] zero
  output logic [M_TDATA_W-1:0]      m_tdata,
  output logic [1:0]                m_tuser,   // [1:0] status
  // Capacity configuration.
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CNT_W-1:0]     cfg_data
);

  // The capacity register is five bits wide, so no more than 31 cells can
  // ever be used; the row is built only as long as it can be used.
  localparam int unsigned MAX_CAP = (1 << CNT_W) - 1;
  localparam int unsigned CELLS = (DEPTH < MAX_CAP) ? DEPTH : MAX_CAP;
  // Stored width: values are 32 bits at the port, trimmed to DATA_W.
  localparam int unsigned SW = (DATA_W < VAL_W) ? DATA_W : VAL_W;
  localparam int unsigned CAP_RESET = (DEPTH < 16) ? DEPTH : 16;

  // Control and statistics registers.
  logic [CNT_W-1:0] capacity;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] peak;
  logic [VAL_W-1:0] push_total;
  logic [VAL_W-1:0] pop_total;

  logic [CNT_W-1:0] fill_next;
  logic [CNT_W-1:0] peak_next;
  logic [VAL_W-1:0] push_total_next;
  logic [VAL_W-1:0] pop_total_next;
  logic [CNT_W-1:0] capacity_next;

  logic             in_fire;
  logic             cfg_fire;
  logic [SW-1:0]    push_val;
  logic             push_ok;
  logic             pop_ok;
  bfs_status_t      status_next;
  logic [VAL_W-1:0] pop_value_next;

  logic [SW-1:0]    cell_q [CELLS];
  bfs_cell_ctl_t    cell_ctl [CELLS];

  // A new request is taken whenever the result register is free or is being
  // emptied in this cycle.
  assign s_tready  = !m_tvalid || m_tready;
  assign in_fire   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;

  assign push_val = s_tdata[SW-1:0];

  // Decode of the request. The null check comes before the full check.
  always_comb begin
    push_ok        = 1'b0;
    pop_ok         = 1'b0;
    status_next    = ST_OK;
    pop_value_next = '0;
    if (s_tuser == REQ_PUSH) begin
      priority if (push_val == '0) begin
        status_next = ST_NULL;
      end else if (fill >= capacity) begin
        status_next = ST_FULL;
      end else begin
        push_ok = 1'b1;
      end
    end else begin
      if (fill == '0) begin
        status_next = ST_EMPTY;
      end else begin
        pop_ok         = 1'b1;
        pop_value_next = VAL_W'(cell_q[0]);
      end
    end
  end

  // Next values of the counters for the current request.
  always_comb begin
    fill_next       = fill;
    peak_next       = peak;
    push_total_next = push_total;
    pop_total_next  = pop_total;
    if (push_ok) begin
      fill_next       = fill + 1'b1;
      push_total_next = push_total + 1'b1;
      if (fill_next > peak) begin
        peak_next = fill_next;
      end
    end else if (pop_ok) begin
      fill_next      = fill - 1'b1;
      pop_total_next = pop_total + 1'b1;
    end
  end

  // Written capacity, clamped to the legal range.
  always_comb begin
    priority if (cfg_data == '0) begin
      capacity_next = CNT_W'(1);
    end else if (32'(cfg_data) > DEPTH) begin
      capacity_next = CNT_W'(DEPTH);
    end else begin
      capacity_next = cfg_data;
    end
  end

  // The row of cells. The head cell holds the oldest entry.
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic [SW-1:0] nbr;

    if (i == CELLS - 1) begin : g_tail
      assign nbr = cell_q[i];
    end else begin : g_body
      assign nbr = cell_q[i + 1];
    end

    assign cell_ctl[i].shift = in_fire && pop_ok;
    assign cell_ctl[i].load  = in_fire && push_ok && (fill == CNT_W'(i));

    bfs_cell #(
      .W (SW)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .load_data (push_val),
      .nbr_data  (nbr),
      .data      (cell_q[i])
    );
  end

  // Control state. A capacity write restarts the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CNT_W'(CAP_RESET);
      fill       <= '0;
      peak       <= '0;
      push_total <= '0;
      pop_total  <= '0;
    end else if (cfg_fire) begin
      capacity   <= capacity_next;
      fill       <= '0;
      peak       <= '0;
      push_total <= '0;
      pop_total  <= '0;
    end else if (in_fire) begin
      fill       <= fill_next;
      peak       <= peak_next;
      push_total <= push_total_next;
      pop_total  <= pop_total_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_tuser <= status_next;
      m_tdata <= {6'd0, peak_next, pop_total_next, push_total_next, fill_next,
                  pop_value_next};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bfs_checker.sv =====
// Port-level checks for the bounded FIFO with statistics, and their binding.
`default_nettype none

module bfs_checker
  import bfs_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata,
  input wire logic [1:0]           m_tuser
);

  // Every accepted request shows a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted request gave no result");

  // A stalled result is held.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Occupancy never exceeds the reported peak.
  a_peak: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[36:32] <= m_tdata[105:101])
    else $error("occupancy above peak");

  // Occupancy equals pushes minus pops since the queue was last cleared.
  a_balance: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[68:37] - m_tdata[100:69]) == 32'(m_tdata[36:32]))
    else $error("totals disagree with occupancy");

  // A refused request returns no value.
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_OK) |-> m_tdata[31:0] == '0)
    else $error("refused request returned a value");

endmodule

bind bounded_fifo_with_stats bfs_checker u_bfs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the bounded FIFO with occupancy and traffic statistics.
`default_nettype none

module tb_top;
  import bfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One result as the block should report it.
  typedef struct {
    bfs_status_t status;
    logic [VAL_W-1:0] pop_value;
    logic [CNT_W-1:0] occupancy;
    logic [VAL_W-1:0] total_pushed;
    logic [VAL_W-1:0] total_popped;
    logic [CNT_W-1:0] peak_occupancy;
  } fifo_reply_t;

  // Tracks the queue contents and statistics that the block should hold,
  // and compares each reply with the oldest one still owed.
  class fifo_reply_tracker;
    logic [VAL_W-1:0] slots [DEPTH_DEFAULT];
    int unsigned rd_ptr;
    int unsigned wr_ptr;
    int unsigned fill;
    int unsigned capacity;
    logic [VAL_W-1:0] pushes;
    logic [VAL_W-1:0] pops;
    int unsigned peak;
    fifo_reply_t owed_replies [$];
    int unsigned mismatches;

    // A capacity write behaves like creating the queue anew.
    function void restart(logic [CNT_W-1:0] raw_capacity);
      capacity = raw_capacity;
      if (capacity < 1) capacity = 1;
      if (capacity > DEPTH_DEFAULT) capacity = DEPTH_DEFAULT;
      rd_ptr = 0;
      wr_ptr = 0;
      fill = 0;
      pushes = '0;
      pops = '0;
      peak = 0;
    endfunction

    // Pointers wrap at the capacity in use, not at the built depth.
    function int unsigned bump(int unsigned ptr);
      int unsigned nxt;
      nxt = ptr + 1;
      if (nxt >= capacity || nxt >= DEPTH_DEFAULT) nxt = 0;
      return nxt;
    endfunction

    function void note_request(bfs_req_t kind, logic [VAL_W-1:0] value);
      fifo_reply_t r;
      r.status = ST_OK;
      r.pop_value = '0;
      if (kind == REQ_PUSH) begin
        // The null check comes ahead of the full check.
        if (value == '0) begin
          r.status = ST_NULL;
        end else if (fill >= capacity) begin
          r.status = ST_FULL;
        end else begin
          slots[wr_ptr] = value;
          wr_ptr = bump(wr_ptr);
          fill++;
          pushes++;
          if (fill > peak) peak = fill;
        end
      end else begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.pop_value = slots[rd_ptr];
          rd_ptr = bump(rd_ptr);
          fill--;
          pops++;
        end
      end
      r.occupancy = fill[CNT_W-1:0];
      r.total_pushed = pushes;
      r.total_popped = pops;
      r.peak_occupancy = peak[CNT_W-1:0];
      owed_replies.push_back(r);
    endfunction

    function int unsigned pending();
      return owed_replies.size();
    endfunction

    function void flag(string field, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, field, want, got);
    endfunction

    function void check_reply(logic [1:0] status, logic [M_TDATA_W-1:0] data);
      fifo_reply_t r;
      if (owed_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: reply with nothing outstanding, status %0d data 0x%h",
                   $time, status, data);
        return;
      end
      r = owed_replies.pop_front();
      if (status != r.status) flag("status", 32'(r.status), 32'(status));
      if (data[31:0] != r.pop_value) flag("pop_value", r.pop_value, data[31:0]);
      if (data[36:32] != r.occupancy) flag("occupancy", 32'(r.occupancy), 32'(data[36:32]));
      if (data[68:37] != r.total_pushed) flag("total_pushed", r.total_pushed, data[68:37]);
      if (data[100:69] != r.total_popped) flag("total_popped", r.total_popped, data[100:69]);
      if (data[105:101] != r.peak_occupancy)
        flag("peak_occupancy", 32'(r.peak_occupancy), 32'(data[105:101]));
      if (data[111:106] != '0) flag("tdata padding", 32'd0, 32'(data[111:106]));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  fifo_reply_tracker tracker = new();

  // Percentages of cycles in which the sender stays idle and the receiver
  // stalls; set per phase by the stimulus process.
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  // Remaining cycles of a forced long stall; counted down by the receiver.
  int unsigned hold_left = 0;

  bounded_fifo_with_stats uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // 12 ns clock period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // The receiver decides its ready at each falling edge. A forced hold keeps
  // m_tready low for a counted number of cycles regardless of the phase, so
  // that the single result register fills and s_tready is withdrawn.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else begin
        m_tready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Every result transaction is checked at the rising edge that accepts it.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_reply(m_tuser, m_tdata);
  end

  // Offers one request, with random idle cycles ahead of it, and records it
  // in the tracker at the edge where the transaction completes.
  task automatic offer_request(bfs_req_t kind, logic [VAL_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = kind;
    s_tdata = value;
    do @(posedge clk); while (!s_tready);
    tracker.note_request(kind, value);
  endtask

  // Returns at a rising edge once every owed reply has come back.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Writes the capacity register; only called once the block is idle.
  task automatic write_capacity(logic [CNT_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    tracker.restart(value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Push data: mostly random, with a share of nulls and the extreme values.
  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(15);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel == 2) return 32'd1;
    return $urandom;
  endfunction

  // A run of random traffic made mostly of whole fill and drain sequences,
  // so that both the full and the empty boundary are hit again and again.
  task automatic random_traffic(int unsigned count);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(9);
      if (pick < 3) begin
        len = tracker.capacity - tracker.fill + $urandom_range(2);
        repeat (len) offer_request(REQ_PUSH, pick_value());
      end else if (pick < 5) begin
        len = tracker.fill + $urandom_range(2);
        repeat (len) offer_request(REQ_POP, '0);
      end else begin
        len = $urandom_range(1, 12);
        repeat (len) begin
          if ($urandom_range(99) < 60) offer_request(REQ_PUSH, pick_value());
          else offer_request(REQ_POP, $urandom);
        end
      end
      sent += len;
    end
  endtask

  // Stalls the receiver for a long stretch while pushes keep coming, then
  // lets the sender wait for every outstanding reply before going on.
  task automatic squeeze();
    hold_left = 48;
    repeat (12) offer_request(REQ_PUSH, pick_value());
    wait_drained();
  endtask

  // Capacity written at the start of each random phase (phase 6 draws a random
  // one): the extremes, the clamped out-of-range values, and a few in between.
  logic [CNT_W-1:0] phase_capacity [8] = '{5'd16, 5'd0, 5'd31, 5'd2, 5'd5, 5'd17, 5'd3, 5'd9};

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = REQ_PUSH;
    cfg_valid = 1'b0;
    cfg_data = '0;
    tracker.restart(5'd16);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed checks at the reset capacity: a pop from the empty queue, a
    // null push, the extreme data values and popping back past empty.
    offer_request(REQ_POP, '0);
    offer_request(REQ_PUSH, '0);
    offer_request(REQ_PUSH, 32'd1);
    offer_request(REQ_PUSH, '1);
    offer_request(REQ_POP, '1);
    offer_request(REQ_POP, '0);
    offer_request(REQ_POP, '0);

    // A capacity of zero is taken as one: the second push must be refused as
    // full, and a null push into the full queue must still report null.
    write_capacity(5'd0);
    offer_request(REQ_PUSH, 32'h5a5a_5a5a);
    offer_request(REQ_PUSH, 32'd2);
    offer_request(REQ_PUSH, '0);
    offer_request(REQ_POP, '0);
    offer_request(REQ_POP, '0);

    // Random phases, each under its own capacity and one of four idling patterns
    // in turn: none, sender idle, receiver stalling, and both idling a little.
    for (int p = 0; p < 8; p++) begin
      write_capacity(p == 6 ? 5'($urandom_range(31)) : phase_capacity[p]);
      case (p % 4)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 81;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 81;
        end
        default: begin
          gap_pct = 9;
          stall_pct = 9;
        end
      endcase
      if (p % 4 == 0) squeeze();
      random_traffic(228);
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2ms;
    $display("tb_top failed");
    $finish;
  end

endmodule

`default_nettype wire
